// ===== sv/ect_pkg.sv =====
// ect_pkg: shared types and constants of the entity component table
// operation and status codes, field widths, controller to datapath structs
// no dependencies
`default_nettype none

package ect_pkg;

  // fixed field widths of the request and result channels
  localparam int FUNC_W = 3;
  localparam int ENT_W  = 6;
  localparam int CID_W  = 5;
  localparam int MASK_W = 32;
  localparam int STAT_W = 2;

  // operation codes carried in func
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CREATE  = 3'd0,
    FUNC_DESTROY = 3'd1,
    FUNC_ALIVE   = 3'd2,
    FUNC_ADD     = 3'd3,
    FUNC_REMOVE  = 3'd4,
    FUNC_HAS     = 3'd5,
    FUNC_FIND    = 3'd6
  } func_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEAD  = 2'd2,
    ST_NEVER = 2'd3
  } status_e;

  // commands from the controller
  typedef struct packed {
    logic accept;      // capture request, launch memory reads, reset scan
    logic exec;        // commit single-handle operation, load its result
    logic scan_step;   // advance the find-all scan by one handle
    logic pend_take;   // hold the evaluated handle as pending match
    logic pend_push;   // send the pending match out, not last
    logic final_emit;  // send the closing find-all result
  } ect_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic find_req;    // request on the input is a find-all
    logic scan_done;   // every allocated handle has been evaluated
    logic match;       // evaluated handle is alive and owns all required components
    logic pend_vld;    // a pending match is held
    logic out_free;    // output register can load this cycle
  } ect_stat_t;

endpackage

`default_nettype wire

// ===== sv/ect_ctrl.sv =====
// ect_ctrl: controller state machine of the entity component table
// sequences request capture, execution and the find-all scan
// depends on ect_pkg
`default_nettype none

module ect_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ect_pkg::ect_stat_t stat_i,
  output ect_pkg::ect_cmd_t      cmd_o
);
  import ect_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.find_req ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          if (stat_i.out_free) begin
            cmd_o.final_emit = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (stat_i.match && stat_i.pend_vld) begin
          // older match goes out before the new one is held
          if (stat_i.out_free) begin
            cmd_o.pend_push = 1'b1;
            cmd_o.pend_take = 1'b1;
            cmd_o.scan_step = 1'b1;
          end
        end else begin
          cmd_o.pend_take = stat_i.match;
          cmd_o.scan_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ect_dpath.sv =====
// ect_dpath: datapath of the entity component table
// free handle ring, ownership memory, alive bits, scan pipeline, output register
// depends on ect_pkg
`default_nettype none

module ect_dpath #(
  parameter int ENTITY_SLOTS    = 64,
  parameter int COMPONENT_TYPES = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ect_pkg::ect_cmd_t           cmd_i,
  output ect_pkg::ect_stat_t               stat_o,
  input  wire logic [ect_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [ect_pkg::ENT_W-1:0]   entity_index_i,
  input  wire logic [ect_pkg::CID_W-1:0]   component_id_i,
  input  wire logic [ect_pkg::MASK_W-1:0]  required_mask_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ect_pkg::ENT_W-1:0]        out_entity_o,
  output logic [ect_pkg::STAT_W-1:0]       status_o,
  output logic                             flag_o,
  output logic                             last_o
);
  import ect_pkg::*;

  localparam int IDX_W = $clog2(ENTITY_SLOTS);
  localparam int CNT_W = $clog2(ENTITY_SLOTS + 1);
  localparam int OWN_W = (COMPONENT_TYPES < MASK_W) ? COMPONENT_TYPES : MASK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTITY_SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS    = CNT_W'(ENTITY_SLOTS);

  // captured request
  func_e             func_q;
  logic [ENT_W-1:0]  ent_q;
  logic [CID_W-1:0]  cid_q;
  logic [MASK_W-1:0] req_q;

  // storage
  logic [OWN_W-1:0] own_mem [ENTITY_SLOTS];
  logic [IDX_W-1:0] fq_mem  [ENTITY_SLOTS];
  logic [OWN_W-1:0] own_rd_q;
  logic [IDX_W-1:0] fq_rd_q;

  // allocator state
  logic [IDX_W-1:0]        head_q, tail_q;
  logic [CNT_W-1:0]        fill_q, count_q;
  logic [ENTITY_SLOTS-1:0] alive_q;

  // scan pipeline
  logic [CNT_W-1:0] scan_ptr_q;
  logic             eval_vld_q;
  logic [IDX_W-1:0] eval_idx_q;
  logic             pend_vld_q;
  logic [IDX_W-1:0] pend_idx_q;

  // output register
  logic              out_valid_q;
  logic [ENT_W-1:0]  out_entity_q;
  logic [STAT_W-1:0] out_status_q;
  logic              out_flag_q;
  logic              out_last_q;

  // execute stage signals
  logic [IDX_W-1:0]  ent_idx;
  logic              allocated;
  logic              alive_ent;
  logic              cid_ok;
  logic [MASK_W-1:0] own32, bit32, new32;
  logic              scan_more, scan_rd;

  logic [ENT_W-1:0]  res_ent;
  status_e           res_st;
  logic              res_flag;
  logic              own_we;
  logic [IDX_W-1:0]  own_waddr;
  logic [OWN_W-1:0]  own_wdata;
  logic              alive_set, alive_clr;
  logic [IDX_W-1:0]  alive_idx;
  logic              pop, push, grow;

  assign ent_idx   = ent_q[IDX_W-1:0];
  assign allocated = {2'b00, ent_q} < 8'(count_q);
  assign alive_ent = alive_q[ent_idx];
  assign cid_ok    = int'(cid_q) < COMPONENT_TYPES;
  assign own32     = MASK_W'(own_rd_q);
  assign bit32     = MASK_W'(1) << cid_q;
  assign new32     = (func_q == FUNC_ADD)    ? (own32 | bit32) :
                     (func_q == FUNC_REMOVE) ? (own32 & ~bit32) : own32;
  assign scan_more = scan_ptr_q < count_q;
  assign scan_rd   = cmd_i.scan_step && scan_more;

  // single-handle operation decode
  always_comb begin
    res_ent   = '0;
    res_st    = ST_OK;
    res_flag  = 1'b0;
    own_we    = 1'b0;
    own_waddr = ent_idx;
    own_wdata = '0;
    alive_set = 1'b0;
    alive_clr = 1'b0;
    alive_idx = ent_idx;
    pop       = 1'b0;
    push      = 1'b0;
    grow      = 1'b0;
    unique case (func_q) inside
      FUNC_CREATE: begin
        if (fill_q != '0) begin
          // reuse oldest freed handle, ownership kept
          res_ent   = ENT_W'(fq_rd_q);
          res_flag  = 1'b1;
          pop       = 1'b1;
          alive_set = 1'b1;
          alive_idx = fq_rd_q;
        end else if (count_q < SLOTS) begin
          // fresh handle starts with no components
          res_ent   = ENT_W'(count_q[IDX_W-1:0]);
          res_flag  = 1'b1;
          grow      = 1'b1;
          own_we    = 1'b1;
          own_waddr = count_q[IDX_W-1:0];
          alive_set = 1'b1;
          alive_idx = count_q[IDX_W-1:0];
        end else begin
          res_st = ST_FULL;
        end
      end
      [FUNC_DESTROY:FUNC_HAS]: begin
        res_ent = ent_q;
        if (!allocated) begin
          res_st = ST_NEVER;
        end else if (func_q == FUNC_ALIVE) begin
          res_flag = alive_ent;
        end else if (!alive_ent) begin
          res_st = ST_DEAD;
        end else if (func_q == FUNC_DESTROY) begin
          push      = 1'b1;
          alive_clr = 1'b1;
          res_flag  = 1'b1;
        end else if (cid_ok) begin
          own_we    = (func_q != FUNC_HAS);
          own_wdata = OWN_W'(new32);
          res_flag  = |(new32 & bit32);
        end
      end
      default: begin
        res_ent = '0;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_e'(func_i);
      ent_q  <= entity_index_i;
      cid_q  <= component_id_i;
      req_q  <= required_mask_i;
    end
  end

  // ownership memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && own_we) begin
      own_mem[own_waddr] <= own_wdata;
    end
    if (cmd_i.accept) begin
      own_rd_q <= own_mem[entity_index_i[IDX_W-1:0]];
    end else if (scan_rd) begin
      own_rd_q <= own_mem[scan_ptr_q[IDX_W-1:0]];
    end
  end

  // free handle ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push) begin
      fq_mem[tail_q] <= ent_idx;
    end
    if (cmd_i.accept) begin
      fq_rd_q <= fq_mem[head_q];
    end
  end

  // allocator counters and alive bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      count_q <= '0;
      alive_q <= '0;
    end else if (cmd_i.exec) begin
      if (pop) begin
        head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
        fill_q <= fill_q - 1'b1;
      end
      if (push) begin
        tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
        fill_q <= fill_q + 1'b1;
      end
      if (grow) begin
        count_q <= count_q + 1'b1;
      end
      if (alive_set) begin
        alive_q[alive_idx] <= 1'b1;
      end
      if (alive_clr) begin
        alive_q[alive_idx] <= 1'b0;
      end
    end
  end

  // find-all scan: read stage then evaluate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_ptr_q <= '0;
      eval_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
    end else if (cmd_i.accept) begin
      scan_ptr_q <= '0;
      eval_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (cmd_i.scan_step) begin
        eval_vld_q <= scan_more;
        if (scan_more) begin
          scan_ptr_q <= scan_ptr_q + 1'b1;
        end
      end
      if (cmd_i.pend_take) begin
        pend_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_rd) begin
      eval_idx_q <= scan_ptr_q[IDX_W-1:0];
    end
    if (cmd_i.pend_take) begin
      pend_idx_q <= eval_idx_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec || cmd_i.pend_push || cmd_i.final_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_entity_q <= res_ent;
      out_status_q <= res_st;
      out_flag_q   <= res_flag;
      out_last_q   <= 1'b1;
    end else if (cmd_i.pend_push) begin
      out_entity_q <= ENT_W'(pend_idx_q);
      out_status_q <= ST_OK;
      out_flag_q   <= 1'b1;
      out_last_q   <= 1'b0;
    end else if (cmd_i.final_emit) begin
      // last match, or the single no-match result
      out_entity_q <= pend_vld_q ? ENT_W'(pend_idx_q) : '0;
      out_status_q <= ST_OK;
      out_flag_q   <= pend_vld_q;
      out_last_q   <= 1'b1;
    end
  end

  // status to the controller
  assign stat_o.find_req  = (func_e'(func_i) == FUNC_FIND);
  assign stat_o.scan_done = !eval_vld_q && !scan_more;
  assign stat_o.match     = eval_vld_q && alive_q[eval_idx_q] &&
                            ((MASK_W'(own_rd_q) & req_q) == req_q);
  assign stat_o.pend_vld  = pend_vld_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_entity_o = out_entity_q;
  assign status_o     = out_status_q;
  assign flag_o       = out_flag_q;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

// ===== sv/entity_component_table.sv =====
// entity_component_table: top level of the entity handle allocator
// joins the controller ect_ctrl and the datapath ect_dpath; depends on ect_pkg
//
//   channel   handshake               payload
//   request   in_valid_i / in_ready_o func_i, entity_index_i, component_id_i,
//                                     required_mask_i
//   result    out_valid_o/out_ready_i out_entity_o, status_o, flag_o, last_o
//
// a single-handle request is accepted with a memory read, then executed
// with read-modify-write of the ownership memory and free ring
// find-all runs through accept, one ownership read per handle, a last
// evaluate, then the closing result, and waits while the result side stalls
// reset clears counters and alive bits at once; no clearing pass is needed
// a finished result waits in the output register while the next request is taken
`default_nettype none

module entity_component_table #(
  parameter int ENTITY_SLOTS    = 64,
  parameter int COMPONENT_TYPES = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ect_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [ect_pkg::ENT_W-1:0]   entity_index_i,
  input  wire logic [ect_pkg::CID_W-1:0]   component_id_i,
  input  wire logic [ect_pkg::MASK_W-1:0]  required_mask_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ect_pkg::ENT_W-1:0]        out_entity_o,
  output logic [ect_pkg::STAT_W-1:0]       status_o,
  output logic                             flag_o,
  output logic                             last_o
);
  import ect_pkg::*;

  ect_cmd_t  cmd;
  ect_stat_t stat;

  ect_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ect_dpath #(
    .ENTITY_SLOTS    (ENTITY_SLOTS),
    .COMPONENT_TYPES (COMPONENT_TYPES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .func_i          (func_i),
    .entity_index_i  (entity_index_i),
    .component_id_i  (component_id_i),
    .required_mask_i (required_mask_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_entity_o    (out_entity_o),
    .status_o        (status_o),
    .flag_o          (flag_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for the entity component table
// drives requests with random gaps, predicts every result, checks them in order
// depends on ect_pkg and entity_component_table
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ect_pkg::*;

  localparam int SLOTS       = 64;
  localparam int TYPES       = 32;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

  typedef struct packed {
    logic [ENT_W-1:0] ent;
    status_e          st;
    logic             flag;
    logic             last;
  } table_result_t;

  // dut ports, known from time zero
  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i          = '0;
  logic [ENT_W-1:0]  entity_index_i  = '0;
  logic [CID_W-1:0]  component_id_i  = '0;
  logic [MASK_W-1:0] required_mask_i = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic [ENT_W-1:0]  out_entity_o;
  logic [STAT_W-1:0] status_o;
  logic              flag_o;
  logic              last_o;

  // shadow copy of the handle table
  logic [ENT_W-1:0]  free_ring [SLOTS] = '{default: '0};
  logic [ENT_W-1:0]  ring_head  = '0;
  logic [6:0]        ring_fill  = '0;
  logic [6:0]        alloc_cnt  = '0;
  logic              alive_map [SLOTS] = '{default: 1'b0};
  logic [MASK_W-1:0] owned_map [SLOTS] = '{default: '0};

  table_result_t pending_results[$];
  int  mismatch_cnt = 0;
  int  quiet_cycles = 0;
  int  hold_off_len = 0;
  bit  idle_on      = 1'b1;

  entity_component_table #(
    .ENTITY_SLOTS    (SLOTS),
    .COMPONENT_TYPES (TYPES)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .entity_index_i  (entity_index_i),
    .component_id_i  (component_id_i),
    .required_mask_i (required_mask_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_entity_o    (out_entity_o),
    .status_o        (status_o),
    .flag_o          (flag_o),
    .last_o          (last_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // queue one expected result
  task automatic push_result(input logic [ENT_W-1:0] ent, input status_e st,
                             input logic flag, input logic last);
    table_result_t r;
    r.ent  = ent;
    r.st   = st;
    r.flag = flag;
    r.last = last;
    pending_results = {pending_results, r};
  endtask

  // update the shadow table for one accepted request, queue its results
  task automatic apply_table_request(input logic [FUNC_W-1:0] f,
                                     input logic [ENT_W-1:0] e,
                                     input logic [CID_W-1:0] c,
                                     input logic [MASK_W-1:0] m);
    logic [ENT_W-1:0]  h;
    logic [ENT_W-1:0]  tail;
    logic [MASK_W-1:0] bit_sel;
    int                hits;
    int                i;
    hits = 0;
    case (f)
      FUNC_CREATE: begin
        if (ring_fill != 0) begin
          // oldest freed handle first, ownership kept
          h = free_ring[ring_head];
          ring_head = ring_head + 1'b1;
          ring_fill = ring_fill - 1'b1;
          alive_map[h] = 1'b1;
          push_result(h, ST_OK, 1'b1, 1'b1);
        end else if (alloc_cnt < SLOTS) begin
          h = alloc_cnt[ENT_W-1:0];
          owned_map[h] = '0;
          alloc_cnt = alloc_cnt + 1'b1;
          alive_map[h] = 1'b1;
          push_result(h, ST_OK, 1'b1, 1'b1);
        end else begin
          push_result('0, ST_FULL, 1'b0, 1'b1);
        end
      end
      FUNC_FIND: begin
        // ascending scan over allocated handles
        for (i = 0; i < alloc_cnt; i++) begin
          if (alive_map[i] && (owned_map[i] & m) == m) begin
            push_result(ENT_W'(i), ST_OK, 1'b1, 1'b0);
            hits++;
          end
        end
        if (hits == 0)
          push_result('0, ST_OK, 1'b0, 1'b1);
        else
          pending_results[pending_results.size()-1].last = 1'b1;
      end
      FUNC_UNUSED: push_result('0, ST_OK, 1'b0, 1'b1);
      default: begin
        if (e >= alloc_cnt) begin
          push_result(e, ST_NEVER, 1'b0, 1'b1);
        end else if (f == FUNC_ALIVE) begin
          push_result(e, ST_OK, alive_map[e], 1'b1);
        end else if (!alive_map[e]) begin
          push_result(e, ST_DEAD, 1'b0, 1'b1);
        end else if (f == FUNC_DESTROY) begin
          tail = ring_head + ring_fill[ENT_W-1:0];
          free_ring[tail] = e;
          if (ring_fill < SLOTS)
            ring_fill = ring_fill + 1'b1;
          alive_map[e] = 1'b0;
          push_result(e, ST_OK, 1'b1, 1'b1);
        end else if (c >= TYPES) begin
          push_result(e, ST_OK, 1'b0, 1'b1);
        end else begin
          bit_sel = MASK_W'(1) << c;
          if (f == FUNC_ADD)
            owned_map[e] = owned_map[e] | bit_sel;
          else if (f == FUNC_REMOVE)
            owned_map[e] = owned_map[e] & ~bit_sel;
          push_result(e, ST_OK, owned_map[e][c], 1'b1);
        end
      end
    endcase
  endtask

  // offer one request, after a random gap when idling is on, wait for its acceptance
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [ENT_W-1:0] e,
                              input logic [CID_W-1:0] c, input logic [MASK_W-1:0] m);
    int unsigned gap;
    gap = idle_on ? $urandom_range(17, 0) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    entity_index_i  <= e;
    component_id_i  <= c;
    required_mask_i <= m;
    do @(posedge clk_i); while (!in_ready_o);
    apply_table_request(f, e, c, m);
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // one random request, handles mostly inside the allocated range
  task automatic send_random_request();
    logic [FUNC_W-1:0] f;
    logic [ENT_W-1:0]  e;
    logic [CID_W-1:0]  c;
    logic [MASK_W-1:0] m;
    int unsigned       pick;
    pick = $urandom_range(99, 0);
    if (pick < 14)      f = FUNC_CREATE;
    else if (pick < 26) f = FUNC_DESTROY;
    else if (pick < 36) f = FUNC_ALIVE;
    else if (pick < 58) f = FUNC_ADD;
    else if (pick < 70) f = FUNC_REMOVE;
    else if (pick < 86) f = FUNC_HAS;
    else if (pick < 96) f = FUNC_FIND;
    else                f = FUNC_UNUSED;
    if (alloc_cnt != 0 && $urandom_range(9, 0) < 8)
      e = ENT_W'($urandom_range(alloc_cnt - 1, 0));
    else
      e = ENT_W'($urandom);
    c = CID_W'($urandom);
    case ($urandom_range(3, 0))
      0:       m = '0;
      1:       m = owned_map[e];
      2:       m = MASK_W'(1) << c;
      default: m = $urandom;
    endcase
    send_request(f, e, c, m);
  endtask

  // single-handle operations other than create on an empty table, plus find-all and an unused code
  task automatic test_unallocated();
    send_request(FUNC_DESTROY, 6'd63, 5'd0, 32'hFFFF_FFFF);
    send_request(FUNC_ALIVE, 6'd0, 5'd31, '0);
    send_request(FUNC_ADD, 6'd5, 5'd31, '0);
    send_request(FUNC_HAS, 6'd0, 5'd0, '0);
    send_request(FUNC_REMOVE, 6'd42, 5'd16, '0);
    send_request(FUNC_FIND, 6'd0, 5'd0, '0);
    send_request(FUNC_UNUSED, 6'd63, 5'd31, 32'hFFFF_FFFF);
    wait_for_results();
  endtask

  // fresh handles, component edges and find-all matching
  task automatic test_component_ops();
    repeat (3) send_request(FUNC_CREATE, ENT_W'($urandom), CID_W'($urandom), $urandom);
    send_request(FUNC_ADD, 6'd0, 5'd0, '0);
    send_request(FUNC_ADD, 6'd0, 5'd31, '0);
    send_request(FUNC_REMOVE, 6'd0, 5'd0, '0);
    send_request(FUNC_HAS, 6'd0, 5'd0, '0);
    send_request(FUNC_ADD, 6'd2, 5'd31, '0);
    send_request(FUNC_FIND, 6'd0, 5'd0, 32'h8000_0000);
    send_request(FUNC_FIND, 6'd0, 5'd0, 32'hFFFF_FFFF);
    wait_for_results();
  endtask

  // destroyed handles answer dead, then come back with their old components
  task automatic test_dead_handles();
    send_request(FUNC_ADD, 6'd1, 5'd7, '0);
    send_request(FUNC_DESTROY, 6'd1, 5'd0, '0);
    send_request(FUNC_DESTROY, 6'd1, 5'd0, '0);
    send_request(FUNC_ALIVE, 6'd1, 5'd0, '0);
    send_request(FUNC_ADD, 6'd1, 5'd3, '0);
    send_request(FUNC_HAS, 6'd1, 5'd7, '0);
    send_request(FUNC_CREATE, 6'd0, 5'd0, '0);
    send_request(FUNC_HAS, 6'd1, 5'd7, '0);
    wait_for_results();
  endtask

  // random traffic, idling switched on and off in stretches
  task automatic test_random_traffic(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 15 == 0)
        idle_on = 1'($urandom_range(1, 0));
      send_random_request();
    end
    wait_for_results();
    idle_on = 1'b1;
  endtask

  // allocate every handle back to back, then hit the full case
  task automatic test_fill_to_capacity();
    idle_on = 1'b0;
    while (alloc_cnt < SLOTS || ring_fill != 0)
      send_request(FUNC_CREATE, ENT_W'($urandom), CID_W'($urandom), $urandom);
    send_request(FUNC_CREATE, 6'd0, 5'd0, '0);
    send_request(FUNC_FIND, 6'd0, 5'd0, '0);
    send_request(FUNC_ADD, 6'd63, 5'd31, '0);
    send_request(FUNC_HAS, 6'd63, 5'd31, '0);
    wait_for_results();
    idle_on = 1'b1;
  endtask

  // long result stall while requests keep coming, then a full drain
  task automatic test_backpressure();
    int n;
    idle_on = 1'b0;
    hold_off_len = HOLD_CYCLES;
    send_request(FUNC_FIND, 6'd0, 5'd0, '0);
    for (n = 0; n < 10; n++)
      send_random_request();
    wait_for_results();
    idle_on = 1'b1;
  endtask

  // result side: random ready gaps, one long hold when asked
  initial begin : result_sink
    int unsigned gap;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = idle_on ? $urandom_range(17, 0) : 0;
      if (hold_off_len != 0) begin
        gap = hold_off_len;
        hold_off_len = 0;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_entity %0d status %0d", out_entity_o, status_o);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_entity_o !== want.ent) begin
          $error("out_entity: expected %0d, got %0d", want.ent, out_entity_o);
          mismatch_cnt++;
        end
        if (status_o !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status_o);
          mismatch_cnt++;
        end
        if (flag_o !== want.flag) begin
          $error("flag: expected %0d, got %0d", want.flag, flag_o);
          mismatch_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unallocated();
    test_component_ops();
    test_dead_handles();
    test_random_traffic(20);
    test_fill_to_capacity();
    test_random_traffic(10);
    test_backpressure();
    repeat (80) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ect_pkg.sv
sv/ect_ctrl.sv
sv/ect_dpath.sv
sv/entity_component_table.sv
tb/sv/tb_top.sv
